// ===== src/ppdh_pkg.sv =====
// shared types and constants of the periodic pair distance histogram
package ppdh_pkg;

	// bin index width and saturation value
	localparam int BIN_BITS = 14;
	localparam logic [BIN_BITS-1:0] BIN_SAT = '1;

	// input commands
	localparam logic CMD_ACC = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// configuration port
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 23;
	localparam int BINS_REG_BITS = 11;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_LENGTH = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_WIDTH = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BINS_IN_USE = 2'd2;

	// register reset values
	localparam logic [CFG_DATA_BITS-1:0] BOX_LENGTH_RST = 23'd1024;
	localparam logic [CFG_DATA_BITS-1:0] BIN_WIDTH_RST = 23'd102;
	localparam logic [BINS_REG_BITS-1:0] BINS_IN_USE_RST = 11'd1024;

	// payload widths
	localparam int WEIGHT_BITS = 2;
	localparam int READ_BIN_BITS = 10;
	localparam int OUT_COUNT_BITS = 32;

	// commands from controller to datapath
	typedef struct packed {
		logic       load;
		logic       fold;
		logic       sq;
		logic       root;
		logic       srch;
		logic [5:0] bit_idx;
		logic       rd;
		logic       upd;
		logic       push;
		logic       clr;
	} ppdh_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_read;
		logic clr_last;
		logic out_free;
	} ppdh_stat_t;

endpackage

// ===== src/ppdh_if.sv =====
// channel interfaces: pair input, result output, configuration write
interface ppdh_pair_if #(parameter int COORD_BITS = 24);
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic signed [COORD_BITS-1:0] first_x;
	logic signed [COORD_BITS-1:0] first_y;
	logic signed [COORD_BITS-1:0] first_z;
	logic signed [COORD_BITS-1:0] second_x;
	logic signed [COORD_BITS-1:0] second_y;
	logic signed [COORD_BITS-1:0] second_z;
	logic [1:0]               pair_weight;
	logic [9:0]               read_bin;
	modport source (output valid, cmd, first_x, first_y, first_z, second_x, second_y, second_z,
		pair_weight, read_bin, input ready);
	modport sink (input valid, cmd, first_x, first_y, first_z, second_x, second_y, second_z,
		pair_weight, read_bin, output ready);
endinterface

interface ppdh_result_if;
	logic        valid;
	logic        ready;
	logic [13:0] pair_bin;
	logic        counted;
	logic [31:0] bin_count;
	modport source (output valid, pair_bin, counted, bin_count, input ready);
	modport sink (input valid, pair_bin, counted, bin_count, output ready);
endinterface

interface ppdh_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [22:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ppdh_ram.sv =====
// generic single write port ram with registered read
module ppdh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/ppdh_ctrl.sv =====
// controller state machine of the pair distance histogram
module ppdh_ctrl import ppdh_pkg::*; #(
	parameter int ROOT_BITS = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ppdh_stat_t stat,
	output ppdh_cmd_t  cmd
);
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_FOLD  = 4'd2;
	localparam logic [3:0] S_SQ    = 4'd3;
	localparam logic [3:0] S_ROOT  = 4'd4;
	localparam logic [3:0] S_SRCH  = 4'd5;
	localparam logic [3:0] S_RD    = 4'd6;
	localparam logic [3:0] S_UPD   = 4'd7;
	localparam logic [3:0] S_PUSH  = 4'd8;

	localparam logic [5:0] ROOT_TOP = 6'(ROOT_BITS - 1);
	localparam logic [5:0] SRCH_TOP = 6'(BIN_BITS - 1);
	localparam logic [5:0] SQ_LAST  = 6'd2;

	logic [3:0] state_q, state_d;
	logic [5:0] cnt_q, cnt_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.bit_idx = cnt_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_FOLD;
				end
			end
			S_FOLD: begin
				cmd.fold = 1'b1;
				cnt_d    = '0;
				state_d  = stat.is_read ? S_RD : S_SQ;
			end
			S_SQ: begin
				cmd.sq = 1'b1;
				cnt_d  = cnt_q + 6'd1;
				if (cnt_q == SQ_LAST) begin
					cnt_d   = ROOT_TOP;
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				cmd.root = 1'b1;
				cnt_d    = cnt_q - 6'd1;
				if (cnt_q == '0) begin
					cnt_d   = SRCH_TOP;
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				cmd.srch = 1'b1;
				cnt_d    = cnt_q - 6'd1;
				if (cnt_q == '0) state_d = S_RD;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end
endmodule

// ===== src/ppdh_datapath.sv =====
// datapath: fold, squared distance, root and bin search on one multiplier, histogram update
module ppdh_datapath import ppdh_pkg::*; #(
	parameter int MAX_BINS = 1024,
	parameter int COORD_BITS = 24,
	parameter int COUNT_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ppdh_cmd_t                    cmd,
	output ppdh_stat_t                   stat,
	input  logic                         in_cmd,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] first_z,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic signed [COORD_BITS-1:0] second_z,
	input  logic [WEIGHT_BITS-1:0]       pair_weight,
	input  logic [READ_BIN_BITS-1:0]     read_bin,
	input  logic                         cfg_valid,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [BIN_BITS-1:0]          out_pair_bin,
	output logic                         out_counted,
	output logic [OUT_COUNT_BITS-1:0]    out_bin_count
);
	localparam int CB = COORD_BITS;
	localparam int RW = CB + 1;
	localparam int SW = 2 * CB + 2;
	localparam int MW = (RW > CFG_DATA_BITS) ? RW : CFG_DATA_BITS;
	localparam int PW = 2 * MW;
	localparam int FW = (CB + 1 > CFG_DATA_BITS + 1) ? CB + 1 : CFG_DATA_BITS + 1;
	localparam int AW = $clog2(MAX_BINS);
	localparam int XW = (AW > BIN_BITS) ? AW : BIN_BITS;
	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_BINS - 1);

	// configuration registers
	logic [CFG_DATA_BITS-1:0] box_q, bw_q;
	logic [BINS_REG_BITS-1:0] bins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q  <= BOX_LENGTH_RST;
			bw_q   <= BIN_WIDTH_RST;
			bins_q <= BINS_IN_USE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BOX_LENGTH:  box_q  <= cfg_data;
				CFG_BIN_WIDTH:   bw_q   <= cfg_data;
				CFG_BINS_IN_USE: bins_q <= cfg_data[BINS_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic signed [CB-1:0] fa_q [3];
	logic signed [CB-1:0] fb_q [3];
	logic                 is_read_q;
	logic [WEIGHT_BITS-1:0]   w_q;
	logic [READ_BIN_BITS-1:0] idx_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fa_q[0]   <= first_x;
			fa_q[1]   <= first_y;
			fa_q[2]   <= first_z;
			fb_q[0]   <= second_x;
			fb_q[1]   <= second_y;
			fb_q[2]   <= second_z;
			is_read_q <= (in_cmd == CMD_READ);
			w_q       <= pair_weight;
			idx_q     <= read_bin;
		end
	end

	// periodic fold of each axis difference
	logic [CB-1:0] fold_m [3];
	logic [CB-1:0] mag_q [3];

	for (genvar a = 0; a < 3; a++) begin : g_fold
		logic signed [CB:0] d;
		logic [CB:0]        ad;
		logic [FW-1:0]      m, m2, box;
		always_comb begin
			d   = (CB+1)'(fa_q[a]) - (CB+1)'(fb_q[a]);
			ad  = d[CB] ? -d : d;
			m   = FW'(ad[CB-1:0]);
			m2  = m << 1;
			box = FW'(box_q);
			fold_m[a] = ad[CB-1:0];
			if (m2 > box) begin
				fold_m[a] = (m >= box) ? CB'(m - box) : CB'(box - m);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fold) begin
			mag_q <= fold_m;
		end
	end

	// shared multiplier
	logic [SW-1:0]       acc_q;
	logic [RW-1:0]       root_q;
	logic [BIN_BITS-1:0] k_q;
	logic [RW-1:0]       root_t;
	logic [BIN_BITS-1:0] k_t;
	logic [MW-1:0]       mul_a, mul_b;
	logic [PW-1:0]       prod;

	assign root_t = root_q | (RW'(1) << cmd.bit_idx);
	assign k_t    = k_q | (BIN_BITS'(1) << cmd.bit_idx);

	always_comb begin
		mul_a = MW'(k_t);
		mul_b = MW'(bw_q);
		if (cmd.sq) begin
			mul_a = MW'(mag_q[cmd.bit_idx[1:0]]);
			mul_b = MW'(mag_q[cmd.bit_idx[1:0]]);
		end else if (cmd.root) begin
			mul_a = MW'(root_t);
			mul_b = MW'(root_t);
		end
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	// squared distance sum, integer root, bin search
	always_ff @(posedge clk) begin
		if (cmd.fold) begin
			acc_q  <= '0;
			root_q <= '0;
			k_q    <= '0;
		end
		if (cmd.sq) begin
			acc_q <= acc_q + prod[SW-1:0];
		end
		if (cmd.root && (prod <= PW'(acc_q))) begin
			root_q <= root_t;
		end
		if (cmd.srch && (prod <= PW'(root_q))) begin
			k_q <= k_t;
		end
	end

	// histogram addressing
	logic [XW-1:0]   idx_ext, k_ext;
	logic [AW-1:0]   rw_addr;
	logic            in_range, in_use;

	assign idx_ext  = XW'(idx_q);
	assign k_ext    = XW'(k_q);
	assign rw_addr  = is_read_q ? idx_ext[AW-1:0] : k_ext[AW-1:0];
	assign in_range = (32'(idx_q) < MAX_BINS);
	assign in_use   = (32'(k_q) < 32'(bins_q)) && (32'(k_q) < MAX_BINS);

	// clearing sweep after reset
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// histogram memory
	logic [COUNT_BITS-1:0] rdata, upd_val, wdata;
	logic [COUNT_BITS:0]   sum;
	logic [AW-1:0]         waddr;
	logic                  we;

	assign sum     = {1'b0, rdata} + (COUNT_BITS+1)'(w_q);
	assign upd_val = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = rw_addr;
		wdata = '0;
		if (cmd.clr) begin
			we    = 1'b1;
			waddr = clr_q;
		end else if (cmd.upd) begin
			we    = is_read_q ? in_range : in_use;
			wdata = is_read_q ? '0 : upd_val;
		end
	end

	ppdh_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BINS)) u_hist (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd),
		.raddr(rw_addr),
		.rdata(rdata)
	);

	// result staging
	logic [63:0]               c64;
	logic [BIN_BITS-1:0]       res_bin_q;
	logic                      res_cnt_q;
	logic [OUT_COUNT_BITS-1:0] res_count_q;

	assign c64 = 64'(rdata);

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			res_bin_q   <= is_read_q ? '0 : k_q;
			res_cnt_q   <= is_read_q ? 1'b0 : in_use;
			res_count_q <= '0;
			if (is_read_q && in_range) begin
				res_count_q <= (c64[63:32] != '0) ? '1 : c64[31:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.push) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_pair_bin  <= res_bin_q;
			out_counted   <= res_cnt_q;
			out_bin_count <= res_count_q;
		end
	end

	assign stat.is_read  = is_read_q;
	assign stat.clr_last = (clr_q == CLR_LAST);
	assign stat.out_free = !out_valid || out_ready;
endmodule

// ===== src/periodic_pair_distance_histogram.sv =====
// Periodic pair distance histogram. After reset the block sweeps the histogram memory to
// zero, one bin a cycle; configuration writes are taken during the sweep but no pair is. An
// accumulate beat then occupies the block while one shared multiplier forms the three squared
// axis distances, the COORD_BITS + 1 steps of the integer square root and the 14 steps of
// the bin search. A read and clear beat passes through the fold, read, update and push states,
// using the read and the write port of the histogram memory. A finished result waits in an
// output register, so the next beat is taken while it is still unclaimed.
module periodic_pair_distance_histogram import ppdh_pkg::*; #(
	parameter int MAX_BINS = 1024,
	parameter int COORD_BITS = 24,
	parameter int COUNT_BITS = 32
) (
	input logic          clk,
	input logic          arst_n,
	ppdh_pair_if.sink    pair,
	ppdh_result_if.source result,
	ppdh_cfg_if.sink     cfg
);
	ppdh_cmd_t  cmd;
	ppdh_stat_t stat;
	logic       in_ready;

	assign pair.ready = in_ready;
	assign cfg.ready  = 1'b1;

	// sequencer
	ppdh_ctrl #(.ROOT_BITS(COORD_BITS + 1)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(pair.valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// arithmetic and histogram
	ppdh_datapath #(
		.MAX_BINS  (MAX_BINS),
		.COORD_BITS(COORD_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_cmd       (pair.cmd),
		.first_x      (pair.first_x),
		.first_y      (pair.first_y),
		.first_z      (pair.first_z),
		.second_x     (pair.second_x),
		.second_y     (pair.second_y),
		.second_z     (pair.second_z),
		.pair_weight  (pair.pair_weight),
		.read_bin     (pair.read_bin),
		.cfg_valid    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.out_pair_bin (result.pair_bin),
		.out_counted  (result.counted),
		.out_bin_count(result.bin_count)
	);
endmodule

// ===== src/ppdh_checker.sv =====
// port level checks of the pair distance histogram and their binding
module ppdh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pair_valid,
	input logic        pair_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [13:0] res_pair_bin,
	input logic        res_counted,
	input logic [31:0] res_bin_count
);
	// a result beat holds until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped before taken");

	// one pair at a time: no beat taken in the cycle after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && pair_ready |=> !pair_ready)
		else $error("input taken while previous beat in flight");

	// a counted pair carries no bin count
	a_counted_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_counted |-> res_bin_count == 32'd0)
		else $error("counted pair with nonzero bin count");

	// a nonzero count comes only from a read beat
	a_count_is_read: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_bin_count != 32'd0 |-> res_pair_bin == 14'd0 && !res_counted)
		else $error("read result with pair fields set");
endmodule

bind periodic_pair_distance_histogram ppdh_checker u_ppdh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pair_valid   (pair.valid),
	.pair_ready   (pair.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_pair_bin (result.pair_bin),
	.res_counted  (result.counted),
	.res_bin_count(result.bin_count)
);
